@@ design/afu_pkg.sv @@
package afu_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = 12;
    localparam int TABLE_DEPTH = 256;

    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int TAB_IDX_W  = $clog2(TABLE_DEPTH + 1);
    localparam int TAB_W      = FRAC_BITS + 1;
    localparam int OPB_W      = DATA_WIDTH + 1;
    localparam int PROD_W     = DATA_WIDTH + OPB_W;
    localparam int DMAG_W     = PROD_W - FRAC_BITS;
    localparam int RES_W      = DMAG_W + 2;

    // divide by 100 as multiply by rounded-up reciprocal, exact for RES_W-bit operands
    localparam int SC_SHIFT   = RES_W + 7;
    localparam int SC_MULT_W  = SC_SHIFT - 6;
    localparam logic [SC_SHIFT:0] SC_POW = {1'b1, {SC_SHIFT{1'b0}}};
    localparam logic [SC_SHIFT:0] SC_MULT_FULL =
        (SC_POW + (SC_SHIFT + 1)'(99)) / (SC_SHIFT + 1)'(100);
    localparam logic [SC_MULT_W-1:0] SC_MULT = SC_MULT_FULL[SC_MULT_W-1:0];

    localparam logic signed [RES_W-1:0] ONE_FX   = RES_W'(longint'(1) << FRAC_BITS);
    localparam logic signed [RES_W-1:0] LEAK_FX  =
        RES_W'(((longint'(1) << FRAC_BITS) + 50) / 100);
    localparam logic [RES_W-1:0]        SC_ROUND = RES_W'(50);

    typedef enum logic [1:0] {
        FUNC_SIGMOID = 2'd0,
        FUNC_RELU    = 2'd1,
        FUNC_TANH    = 2'd2
    } func_t;

    typedef enum logic {
        REQ_FORWARD = 1'b0,
        REQ_DERIV   = 1'b1
    } req_t;

    typedef struct packed {
        req_t       req;
        logic [1:0] func;
        logic       last;
        logic       neg;
    } afu_tag_t;

    typedef struct packed {
        afu_tag_t                       tag;
        logic signed [DATA_WIDTH-1:0]   x;
        logic [IDX_W-1:0]               idx;
        logic [DATA_WIDTH-1:0]          fr;
        logic signed [OPB_W-1:0]        opb;
    } afu_s1_t;

    typedef struct packed {
        afu_tag_t                       tag;
        logic signed [DATA_WIDTH-1:0]   x;
        logic [TAB_W-1:0]               sig;
        logic [DMAG_W-1:0]              dmag;
        logic                           dneg;
    } afu_s3_t;

    // sigmoid table, built at elaboration in Q30 then rounded to FRAC_BITS
    localparam logic [63:0] EXP_M1_Q30 = 64'd395007542;
    localparam logic [63:0] Q30        = 64'd1 << 30;

    typedef logic [TAB_W-1:0] sig_tab_t [TABLE_DEPTH+1];

    // shift-subtract quotient, only used while the table is built
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_neg_q30(input logic [63:0] k, input logic [63:0] f);
        logic [63:0]        ek;
        logic [63:0]        term;
        logic signed [63:0] sum;
        ek   = Q30;
        term = Q30;
        sum  = signed'(Q30);
        for (int j = 0; j < 64; j++)
        begin
            if ((64'(j) < k) && (ek != 64'd0))
            begin
                ek = (ek * EXP_M1_Q30) >> 30;
            end
        end
        for (int j = 1; j <= 20; j++)
        begin
            term = udiv64((term * f) >> 30, 64'(j));
            if ((j % 2) == 1)
            begin
                sum = sum - signed'(term);
            end
            else
            begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0)
        begin
            sum = '0;
        end
        return (ek * unsigned'(sum)) >> 30;
    endfunction

    function automatic sig_tab_t build_sig_tab();
        sig_tab_t    tab;
        logic [63:0] num;
        logic [63:0] k;
        logic [63:0] f;
        logic [63:0] den;
        logic [63:0] s;
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            num    = 64'(i) << (DATA_WIDTH - FRAC_BITS);
            k      = udiv64(num, 64'(TABLE_DEPTH));
            f      = udiv64((num - k * 64'(TABLE_DEPTH)) << 30, 64'(TABLE_DEPTH));
            den    = Q30 + exp_neg_q30(k, f);
            s      = udiv64((64'd1 << 60) + (den >> 1), den);
            tab[i] = TAB_W'((s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

@@ design/afu_if.sv @@
interface afu_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  req_type;
    logic signed [afu_pkg::DATA_WIDTH-1:0] value_in;
    logic                                  last_in;

    modport source (output valid, req_type, value_in, last_in, input ready);
    modport sink   (input valid, req_type, value_in, last_in, output ready);
endinterface

interface afu_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [afu_pkg::DATA_WIDTH-1:0] value_out;
    logic                                  last_out;

    modport source (output valid, value_out, last_out, input ready);
    modport sink   (input valid, value_out, last_out, output ready);
endinterface

@@ design/afu_front.sv @@
module afu_front (
    input  logic                                  clk,
    input  logic                                  en,
    input  afu_pkg::req_t                         req,
    input  logic [1:0]                            func,
    input  logic signed [afu_pkg::DATA_WIDTH-1:0] x,
    input  logic                                  last,
    output afu_pkg::afu_s1_t                      s1
);

    localparam int W  = afu_pkg::DATA_WIDTH;
    localparam int PW = W + afu_pkg::IDX_W + 1;

    afu_pkg::afu_s1_t s1_reg;
    afu_pkg::afu_s1_t s1_next;

    logic signed [W:0]          a;
    logic [W:0]                 a_mag;
    logic [W-1:0]               m;
    logic [PW-1:0]              p;
    logic [afu_pkg::IDX_W:0]    idx_full;

    always_comb
    begin
        // tanh reads the table at 2x
        if (func == afu_pkg::FUNC_TANH)
        begin
            a = {x, 1'b0};
        end
        else
        begin
            a = {x[W-1], x};
        end
        a_mag = a[W] ? (W + 1)'(-a) : (W + 1)'(a);
        m     = a_mag[W] ? '1 : a_mag[W-1:0];
        p     = PW'(m) * PW'(afu_pkg::TABLE_DEPTH);
        idx_full = (afu_pkg::IDX_W + 1)'(p >> W);

        s1_next.tag.req  = req;
        s1_next.tag.func = func;
        s1_next.tag.last = last;
        s1_next.tag.neg  = x[W-1];
        s1_next.x        = x;
        if (idx_full >= (afu_pkg::IDX_W + 1)'(afu_pkg::TABLE_DEPTH))
        begin
            s1_next.idx = afu_pkg::IDX_W'(afu_pkg::TABLE_DEPTH - 1);
            s1_next.fr  = '1;
        end
        else
        begin
            s1_next.idx = idx_full[afu_pkg::IDX_W-1:0];
            s1_next.fr  = p[W-1:0];
        end
        // derivative multiplier operand: y*(1-y) for sigmoid, y*y for tanh
        if (func == afu_pkg::FUNC_SIGMOID)
        begin
            s1_next.opb = afu_pkg::OPB_W'(afu_pkg::ONE_FX) - afu_pkg::OPB_W'(x);
        end
        else
        begin
            s1_next.opb = afu_pkg::OPB_W'(x);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

@@ design/afu_interp.sv @@
module afu_interp (
    input  logic             clk,
    input  logic [1:0]       en,
    input  afu_pkg::afu_s1_t s1,
    output afu_pkg::afu_s3_t s3
);

    localparam int W   = afu_pkg::DATA_WIDTH;
    localparam int TW  = afu_pkg::TAB_W;
    localparam int IW  = TW + W;
    localparam int PRW = afu_pkg::PROD_W;

    typedef struct packed {
        afu_pkg::afu_tag_t          tag;
        logic signed [W-1:0]        x;
        logic [TW-1:0]              lo;
        logic [TW-1:0]              diff;
        logic [W-1:0]               fr;
        logic signed [PRW-1:0]      prod;
    } s2_t;

    s2_t              s2_reg;
    s2_t              s2_next;
    afu_pkg::afu_s3_t s3_reg;
    afu_pkg::afu_s3_t s3_next;

    logic [TW-1:0]  lo;
    logic [TW-1:0]  hi;
    logic [IW-1:0]  ip;
    logic [PRW-1:0] pmag;
    logic [PRW-1:0] prnd;

    // stage 2: table read at both ends of the segment, derivative product
    always_comb
    begin
        lo = afu_pkg::SIG_TAB[afu_pkg::TAB_IDX_W'(s1.idx)];
        hi = afu_pkg::SIG_TAB[afu_pkg::TAB_IDX_W'(s1.idx) + afu_pkg::TAB_IDX_W'(1)];
        s2_next.tag  = s1.tag;
        s2_next.x    = s1.x;
        s2_next.lo   = lo;
        s2_next.diff = (hi > lo) ? (hi - lo) : '0;
        s2_next.fr   = s1.fr;
        s2_next.prod = PRW'(s1.x) * PRW'(s1.opb);
    end

    // stage 3: interpolation, rounded product magnitude
    always_comb
    begin
        ip   = ((IW'(s2_reg.diff) * IW'(s2_reg.fr)) + (IW'(1) << (W - 1))) >> W;
        pmag = s2_reg.prod[PRW-1] ? PRW'(-s2_reg.prod) : PRW'(s2_reg.prod);
        prnd = (pmag + (PRW'(1) << (afu_pkg::FRAC_BITS - 1))) >> afu_pkg::FRAC_BITS;
        s3_next.tag  = s2_reg.tag;
        s3_next.x    = s2_reg.x;
        s3_next.sig  = s2_reg.lo + TW'(ip);
        s3_next.dmag = prnd[afu_pkg::DMAG_W-1:0];
        s3_next.dneg = s2_reg.prod[PRW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s2_reg <= s2_next;
        end
        if (en[1])
        begin
            s3_reg <= s3_next;
        end
    end

    assign s3 = s3_reg;

endmodule

@@ design/afu_post.sv @@
module afu_post (
    input  logic                                  clk,
    input  logic [2:0]                            en,
    input  afu_pkg::afu_s3_t                      s3,
    output logic signed [afu_pkg::DATA_WIDTH-1:0] value_out,
    output logic                                  last_out
);

    localparam int W  = afu_pkg::DATA_WIDTH;
    localparam int RW = afu_pkg::RES_W;
    localparam int MW = RW + afu_pkg::SC_MULT_W;

    localparam logic signed [RW:0] SAT_HI = (RW + 1)'((longint'(1) << (W - 1)) - 1);
    localparam logic signed [RW:0] SAT_LO = -SAT_HI - (RW + 1)'(1);

    typedef struct packed {
        logic                  last;
        logic signed [RW-1:0]  r;
        logic                  scale;
        logic                  add_one;
    } s4_t;

    typedef struct packed {
        logic                  last;
        logic signed [RW-1:0]  r;
        logic                  scale;
        logic                  add_one;
        logic [MW-1:0]         sc_prod;
    } s5_t;

    s4_t s4_reg;
    s4_t s4_next;
    s5_t s5_reg;
    s5_t s5_next;

    logic signed [W-1:0] value_reg;
    logic signed [W-1:0] value_next;
    logic                last_reg;

    logic signed [RW-1:0] xs;
    logic signed [RW-1:0] sg;
    logic signed [RW-1:0] dm;
    logic [RW-1:0]        mag;
    logic [RW-1:0]        q;
    logic signed [RW:0]   qs;
    logic signed [RW:0]   v;

    // stage 4: result before the 0.01 leak scaling
    always_comb
    begin
        xs = RW'(s3.x);
        dm = $signed(RW'(s3.dmag));
        if (s3.tag.neg)
        begin
            sg = afu_pkg::ONE_FX - $signed(RW'(s3.sig));
        end
        else
        begin
            sg = $signed(RW'(s3.sig));
        end
        s4_next.last    = s3.tag.last;
        s4_next.r       = '0;
        s4_next.scale   = 1'b0;
        s4_next.add_one = 1'b0;
        case (s3.tag.func)
            afu_pkg::FUNC_SIGMOID:
            begin
                if (s3.tag.req == afu_pkg::REQ_DERIV)
                begin
                    s4_next.r = s3.dneg ? -dm : dm;
                end
                else
                begin
                    s4_next.r = sg;
                end
            end
            afu_pkg::FUNC_RELU:
            begin
                if (s3.tag.req == afu_pkg::REQ_DERIV)
                begin
                    s4_next.r = (s3.tag.neg || (xs > afu_pkg::ONE_FX)) ?
                                afu_pkg::LEAK_FX : afu_pkg::ONE_FX;
                end
                else if (s3.tag.neg)
                begin
                    s4_next.r     = xs;
                    s4_next.scale = 1'b1;
                end
                else if (xs > afu_pkg::ONE_FX)
                begin
                    // above one the slope drops to 0.01
                    s4_next.r       = xs - afu_pkg::ONE_FX;
                    s4_next.scale   = 1'b1;
                    s4_next.add_one = 1'b1;
                end
                else
                begin
                    s4_next.r = xs;
                end
            end
            afu_pkg::FUNC_TANH:
            begin
                if (s3.tag.req == afu_pkg::REQ_DERIV)
                begin
                    s4_next.r = afu_pkg::ONE_FX - dm;
                end
                else
                begin
                    s4_next.r = (sg <<< 1) - afu_pkg::ONE_FX;
                end
                s4_next.scale = s3.tag.neg;
            end
            default:
            begin
                s4_next.r = '0;
            end
        endcase
    end

    // stage 5: magnitude rounded and multiplied by the reciprocal of 100
    always_comb
    begin
        mag = s4_reg.r[RW-1] ? RW'(-s4_reg.r) : RW'(s4_reg.r);
        s5_next.last    = s4_reg.last;
        s5_next.r       = s4_reg.r;
        s5_next.scale   = s4_reg.scale;
        s5_next.add_one = s4_reg.add_one;
        s5_next.sc_prod = MW'(mag + afu_pkg::SC_ROUND) * MW'(afu_pkg::SC_MULT);
    end

    // stage 6: restore sign, offset and saturate
    always_comb
    begin
        q  = RW'(s5_reg.sc_prod >> afu_pkg::SC_SHIFT);
        qs = s5_reg.r[RW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (s5_reg.scale)
        begin
            v = qs + (s5_reg.add_one ? (RW + 1)'(afu_pkg::ONE_FX) : (RW + 1)'(0));
        end
        else
        begin
            v = (RW + 1)'(s5_reg.r);
        end
        if (v > SAT_HI)
        begin
            value_next = SAT_HI[W-1:0];
        end
        else if (v < SAT_LO)
        begin
            value_next = SAT_LO[W-1:0];
        end
        else
        begin
            value_next = v[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s4_reg <= s4_next;
        end
        if (en[1])
        begin
            s5_reg <= s5_next;
        end
        if (en[2])
        begin
            value_reg <= value_next;
            last_reg  <= s5_reg.last;
        end
    end

    assign value_out = value_reg;
    assign last_out  = last_reg;

endmodule

@@ design/activation_function_unit.sv @@
// Elementwise activation unit: sigmoid, clipped leaky ReLU or leaky tanh on
// signed Q3.12 operands, forward value or derivative per request.
//
// operand channel: valid/ready with req_type (0 forward, 1 derivative from
//   the activation output), value_in and last_in
// result channel: valid/ready with value_out (saturated Q3.12) and last_out,
//   a copy of last_in; results come back in request order
// cfg_we/cfg_wdata write func_select (0 sigmoid, 1 relu, 2 tanh, 3 gives
//   zero); write it only while no request is in flight
//
// six register stages: operand prep and table index, table read and
// derivative multiply, interpolation multiply, result select, divide-by-100
// multiply, saturation and output register. one request per cycle is
// taken when the result side keeps up. the three multipliers set the
// depth of the pipe.
// reset clears all stage valid bits and sets func_select to sigmoid.
// when the receiver holds ready low, the pipe fills its empty stages and then
// drops operand ready; nothing is lost or repeated.
module activation_function_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    afu_in_if.sink     operand,
    afu_out_if.source  result
);

    localparam int NUM_STAGES = 6;

    logic [1:0]              func_sel_reg;
    logic [NUM_STAGES:1]     valid_reg;
    logic [NUM_STAGES:1]     valid_next;
    logic [NUM_STAGES+1:1]   en;

    afu_pkg::afu_s1_t s1;
    afu_pkg::afu_s3_t s3;

    // a stage advances when it is empty or the stage after it advances
    always_comb
    begin
        en[NUM_STAGES+1] = result.ready;
        for (int i = NUM_STAGES; i >= 1; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next = {valid_reg[NUM_STAGES-1:1], operand.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            func_sel_reg <= afu_pkg::FUNC_SIGMOID;
        end
        else
        begin
            for (int i = 1; i <= NUM_STAGES; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
            if (cfg_we)
            begin
                func_sel_reg <= cfg_wdata;
            end
        end
    end

    afu_front u_front (
        .clk  (clk),
        .en   (en[1]),
        .req  (afu_pkg::req_t'(operand.req_type)),
        .func (func_sel_reg),
        .x    (operand.value_in),
        .last (operand.last_in),
        .s1   (s1)
    );

    afu_interp u_interp (
        .clk (clk),
        .en  (en[3:2]),
        .s1  (s1),
        .s3  (s3)
    );

    afu_post u_post (
        .clk       (clk),
        .en        (en[6:4]),
        .s3        (s3),
        .value_out (result.value_out),
        .last_out  (result.last_out)
    );

    assign operand.ready = en[1];
    assign result.valid  = valid_reg[NUM_STAGES];

endmodule

@@ design/afu_checker.sv @@
module afu_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [afu_pkg::DATA_WIDTH-1:0] value_out,
    input logic                                  last_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(value_out) && $stable(last_out))
        else $error("result payload changed while stalled");

    // operand side only backs off when the whole pipe is full and stalled
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("operand ready low without a stalled result");

    // with the result side ready throughout, an accepted request comes out as a valid result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
        ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result missing after pipeline latency");

endmodule

bind activation_function_unit afu_checker u_afu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (operand.valid),
    .in_ready  (operand.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .value_out (result.value_out),
    .last_out  (result.last_out)
);
